[rtl/core/bba_pkg.sv]
// Shared constants, codes and payload types of the buddy block allocator.
package bba_pkg;

   localparam int NUM_BLOCKS  = 256;
   // Largest power of two not above NUM_BLOCKS is the managed pool.
   localparam int TREE_LEVELS = $clog2(NUM_BLOCKS + 1) - 1;
   localparam int POOL_BLOCKS = 1 << TREE_LEVELS;
   localparam int NODE_COUNT  = 2 * POOL_BLOCKS - 1;
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int SPAN_W      = TREE_LEVELS + 1;
   localparam int LVL_W       = $clog2(TREE_LEVELS + 1);

   localparam int SHIFT_W     = 4;
   localparam int SHIFT_MIN   = 2;
   localparam int SHIFT_MAX   = 12;
   localparam int SHIFT_RESET = 6;

   localparam int OFFSET_W    = 20;
   localparam int BYTES_W     = 21;

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;
   localparam logic [1:0] STATUS_NOT_ALLOC = 2'd3;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [SPAN_W-1:0] span_type;
   typedef logic [LVL_W-1:0]  lvl_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [BYTES_W-1:0]  req_bytes;
      logic [OFFSET_W-1:0] byte_offset;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [OFFSET_W-1:0] alloc_offset;
      logic [BYTES_W-1:0]  span_bytes;
   } rsp_payload_type;

endpackage

[rtl/core/bba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/buddy_block_allocator_top.sv]
// Buddy block allocator: free-span tree in RAM, walked by one sequencer.
// Allocate descends from the root to the granted level, then rewrites the path back up;
// free climbs from the leaf to the used node, then rewrites the path back up; query only
// climbs; requests rejected at decode go straight to the finish step. One request in flight:
// req_ready returns with rsp_valid, and an untaken result holds the finish step, req_ready low.
// Reset sweeps the tree RAM, one node a cycle, req_ready low.
module buddy_block_allocator_top
   import bba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SHIFT_W-1:0]   csr_data
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ROOT,
      S_DESCEND,
      S_CLIMB,
      S_ASCEND,
      S_FINISH
   } state_type;

   // Sibling and parent in a heap-ordered tree rooted at node 0.
   function automatic node_type sibling_of(input node_type n);
      node_type s;
      s = n[0] ? n + 1'b1 : n - 1'b1;
      return s;
   endfunction

   function automatic node_type parent_of(input node_type n);
      node_type p;
      p = (n - 1'b1) >> 1;
      return p;
   endfunction

   state_type           state_ff, state_in;
   node_type            clr_ff, clr_in;
   span_type            fill_ff, fill_in;
   logic [SHIFT_W-1:0]  shift_ff;
   logic [1:0]          mode_ff, mode_in;
   lvl_type             k_ff, k_in;
   node_type            idx_ff, idx_in;
   lvl_type             lvl_ff, lvl_in;
   span_type            cur_ff, cur_in;
   logic                merge_ff, merge_in;
   rsp_payload_type     res_ff, res_in;
   rsp_payload_type     rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Tree RAM port
   logic                ram_wr_en;
   node_type            ram_wr_addr;
   span_type            ram_wr_data;
   logic                ram_rd_en;
   node_type            ram_rd_addr;
   span_type            ram_rd_data;

   // Request decode
   logic [SHIFT_W-1:0]  eff_sh;
   logic [BYTES_W:0]    round_add;
   logic [BYTES_W:0]    cnt_wide;
   span_type            cnt;
   lvl_type             req_k;
   logic [OFFSET_W-1:0] blk_wide;
   node_type            leaf_idx;

   // Descent and ascent datapath
   span_type            blocks_val;
   logic                fit;
   node_type            desc_idx;
   lvl_type             desc_lvl;
   node_type            desc_left;
   logic [NODE_W+TREE_LEVELS-1:0] pos_wide;
   node_type            par_idx;
   lvl_type             par_lvl;
   span_type            par_full;
   logic [SPAN_W:0]     pair_sum;
   span_type            pair_max;
   span_type            par_val;
   logic [NODE_W:0]     clr_next;
   logic [4:0]          span_sh;

   bba_ram #(
      .WIDTH (SPAN_W),
      .DEPTH (NODE_COUNT)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Clamp the block shift into its legal range.
   always_comb begin
      if (shift_ff < SHIFT_W'(SHIFT_MIN)) begin
         eff_sh = SHIFT_W'(SHIFT_MIN);
      end else if (shift_ff > SHIFT_W'(SHIFT_MAX)) begin
         eff_sh = SHIFT_W'(SHIFT_MAX);
      end else begin
         eff_sh = shift_ff;
      end
   end

   // Round bytes up to blocks, then blocks up to a power of two.
   assign round_add = ((BYTES_W+1)'(1) << eff_sh) - (BYTES_W+1)'(1);
   assign cnt_wide  = ((BYTES_W+1)'(req_data.req_bytes) + round_add) >> eff_sh;
   assign cnt       = cnt_wide[SPAN_W-1:0];

   always_comb begin
      req_k = LVL_W'(TREE_LEVELS);
      for (int i = TREE_LEVELS; i >= 0; i--) begin
         if ((SPAN_W'(1) << i) >= cnt) begin
            req_k = LVL_W'(i);
         end
      end
   end

   assign blk_wide = req_data.byte_offset >> eff_sh;
   assign leaf_idx = NODE_W'(blk_wide[TREE_LEVELS-1:0]) + NODE_W'(POOL_BLOCKS - 1);

   // Descent: the root step checks fit, deeper steps pick left when it fits.
   assign blocks_val = SPAN_W'(1) << k_ff;
   assign fit        = (ram_rd_data >= blocks_val);
   assign desc_idx   = (state_ff == S_ROOT) ? '0
                     : (fit ? {idx_ff[NODE_W-2:0], 1'b1} : {idx_ff[NODE_W-2:0], 1'b1} + 1'b1);
   assign desc_lvl   = (state_ff == S_ROOT) ? LVL_W'(TREE_LEVELS) : lvl_ff - 1'b1;
   assign desc_left  = {desc_idx[NODE_W-2:0], 1'b1};
   assign pos_wide   = ((NODE_W+TREE_LEVELS)'(desc_idx) + 1'b1) << k_ff;

   // Ascent: rebuild the parent from the node just written and its sibling.
   assign par_idx  = parent_of(idx_ff);
   assign par_lvl  = lvl_ff + 1'b1;
   assign par_full = SPAN_W'(1) << par_lvl;
   assign pair_sum = {1'b0, cur_ff} + {1'b0, ram_rd_data};
   assign pair_max = (cur_ff > ram_rd_data) ? cur_ff : ram_rd_data;
   assign par_val  = (merge_ff && (pair_sum == {1'b0, par_full})) ? par_full : pair_max;

   assign clr_next = {1'b0, clr_ff} + 1'b1;
   assign span_sh  = (state_ff == S_CLIMB) ? 5'(lvl_ff) + 5'(eff_sh) : 5'(k_ff) + 5'(eff_sh);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      fill_in      = fill_ff;
      mode_in      = mode_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      merge_in     = merge_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep every node to its full span; halve at each new depth.
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = fill_ff;
            clr_in      = clr_next[NODE_W-1:0];
            if (((clr_next + 1'b1) & clr_next) == '0) begin
               fill_in = fill_ff >> 1;
            end
            if (clr_ff == NODE_W'(NODE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               mode_in = req_data.mode;
               res_in  = '0;
               priority if (req_data.mode == MODE_ALLOC) begin
                  if (req_data.req_bytes == '0
                      || cnt_wide > (BYTES_W+1)'(POOL_BLOCKS)) begin
                     res_in.status = STATUS_NO_SPACE;
                     state_in      = S_FINISH;
                  end else begin
                     // Read the root to check the largest free span.
                     k_in        = req_k;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = S_ROOT;
                  end
               end else if (req_data.mode == MODE_FREE || req_data.mode == MODE_QUERY) begin
                  if (blk_wide >= OFFSET_W'(POOL_BLOCKS)) begin
                     res_in.status = STATUS_RANGE;
                     state_in      = S_FINISH;
                  end else begin
                     // Start the climb at the leaf of the offset.
                     idx_in      = leaf_idx;
                     lvl_in      = '0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = leaf_idx;
                     state_in    = S_CLIMB;
                  end
               end else begin
                  res_in.status = STATUS_NO_SPACE;
                  state_in      = S_FINISH;
               end
            end
         end

         S_ROOT, S_DESCEND: begin
            if (state_ff == S_ROOT && !fit) begin
               res_in.status = STATUS_NO_SPACE;
               state_in      = S_FINISH;
            end else if (desc_lvl == k_ff) begin
               // Grant this node: mark it used and start the walk back up.
               ram_wr_en           = 1'b1;
               ram_wr_addr         = desc_idx;
               ram_wr_data         = '0;
               idx_in              = desc_idx;
               lvl_in              = desc_lvl;
               cur_in              = '0;
               merge_in            = 1'b0;
               res_in.status       = STATUS_OK;
               res_in.alloc_offset = OFFSET_W'(pos_wide[TREE_LEVELS-1:0]) << eff_sh;
               res_in.span_bytes   = BYTES_W'(1) << span_sh;
               if (desc_idx == '0) begin
                  state_in = S_FINISH;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = sibling_of(desc_idx);
                  state_in    = S_ASCEND;
               end
            end else begin
               idx_in      = desc_idx;
               lvl_in      = desc_lvl;
               ram_rd_en   = 1'b1;
               ram_rd_addr = desc_left;
               state_in    = S_DESCEND;
            end
         end

         S_CLIMB: begin
            if (ram_rd_data == '0) begin
               // Used node found: its level gives the allocation span.
               res_in.status     = STATUS_OK;
               res_in.span_bytes = BYTES_W'(1) << span_sh;
               if (mode_ff == MODE_QUERY) begin
                  state_in = S_FINISH;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_ff;
                  ram_wr_data = SPAN_W'(1) << lvl_ff;
                  cur_in      = SPAN_W'(1) << lvl_ff;
                  merge_in    = 1'b1;
                  if (idx_ff == '0) begin
                     state_in = S_FINISH;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = sibling_of(idx_ff);
                     state_in    = S_ASCEND;
                  end
               end
            end else if (idx_ff == '0) begin
               res_in.status = STATUS_NOT_ALLOC;
               state_in      = S_FINISH;
            end else begin
               idx_in      = par_idx;
               lvl_in      = par_lvl;
               ram_rd_en   = 1'b1;
               ram_rd_addr = par_idx;
            end
         end

         S_ASCEND: begin
            // Write the parent and fetch the parent's sibling in the same cycle.
            ram_wr_en   = 1'b1;
            ram_wr_addr = par_idx;
            ram_wr_data = par_val;
            idx_in      = par_idx;
            lvl_in      = par_lvl;
            cur_in      = par_val;
            if (par_idx == '0) begin
               state_in = S_FINISH;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = sibling_of(par_idx);
            end
         end

         S_FINISH: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         fill_ff      <= SPAN_W'(POOL_BLOCKS);
         shift_ff     <= SHIFT_W'(SHIFT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            shift_ff <= csr_data;
         end
         mode_ff  <= mode_in;
         k_ff     <= k_in;
         idx_ff   <= idx_in;
         lvl_ff   <= lvl_in;
         cur_ff   <= cur_in;
         merge_ff <= merge_in;
         res_ff   <= res_in;
         rsp_ff   <= rsp_in;
      end
   end

   // A node is never read in the cycle it is written.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
      else $error("tree RAM read and write collide");

   // A new result only comes out of the finish step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_FINISH)
      else $error("result raised outside finish");

   // Errors carry no offset and no span.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
         rsp_data.alloc_offset == '0 && rsp_data.span_bytes == '0)
      else $error("error result with payload");

   // A granted region is aligned to its own size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK |->
         (rsp_data.alloc_offset & OFFSET_W'(rsp_data.span_bytes - 1'b1)) == '0)
      else $error("granted offset not aligned to span");

   // Tree level stays within the tree while walking.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLIMB || state_ff == S_ASCEND || state_ff == S_DESCEND) |->
         lvl_ff <= LVL_W'(TREE_LEVELS))
      else $error("tree level out of range");

endmodule
